/* hw/rtl/awb_pkg.sv */
package awb_pkg;

  // Largest frame dimension the position counters have to cover.
  localparam int MAX_FRAME_DIM = 4096;
  localparam int CNT_W         = $clog2(MAX_FRAME_DIM);

  // Fixed field widths.
  localparam int PIX_W       = 8;
  localparam int DIM_W       = 13;
  localparam int OFFS_W      = 12;
  localparam int ADDR_W      = 25;
  localparam int SIZE_W      = 2 * DIM_W;
  localparam int FSZ_W       = SIZE_W + 1;
  localparam int ADDR_FULL_W = SIZE_W + 2;
  localparam int POS_W       = ((CNT_W > OFFS_W) ? CNT_W : OFFS_W) + 1;
  localparam int INC_W       = ((CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W);
  localparam int CFG_DATA_W  = DIM_W;
  localparam int CFG_IDX_W   = 3;
  localparam int SUM_W       = 18;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_HEIGHT  = 3'd5;

  // Register reset values.
  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
  localparam logic [OFFS_W-1:0] MARK_X_RST       = 12'd0;
  localparam logic [OFFS_W-1:0] MARK_Y_RST       = 12'd0;
  localparam logic [DIM_W-1:0]  MARK_WIDTH_RST   = 13'd64;
  localparam logic [DIM_W-1:0]  MARK_HEIGHT_RST  = 13'd64;
  localparam logic [SIZE_W-1:0] LUMA_SIZE_RST    = SIZE_W'(640 * 480);
  localparam logic [FSZ_W-1:0]  FRAME_SIZE_RST   = FSZ_W'(640 * 480 * 3 / 2);

  // BT.601 integer coefficients.
  localparam logic signed [SUM_W-1:0] CY_R = 18'sd66;
  localparam logic signed [SUM_W-1:0] CY_G = 18'sd129;
  localparam logic signed [SUM_W-1:0] CY_B = 18'sd25;
  localparam logic signed [SUM_W-1:0] CU_R = -18'sd38;
  localparam logic signed [SUM_W-1:0] CU_G = -18'sd74;
  localparam logic signed [SUM_W-1:0] CU_B = 18'sd112;
  localparam logic signed [SUM_W-1:0] CV_R = 18'sd112;
  localparam logic signed [SUM_W-1:0] CV_G = -18'sd94;
  localparam logic signed [SUM_W-1:0] CV_B = -18'sd18;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = 18'sd128;
  localparam logic [PIX_W-1:0] LUMA_BIAS   = 8'd16;
  localparam logic [PIX_W-1:0] CHROMA_BIAS = 8'd128;
  localparam logic [PIX_W-1:0] ALPHA_FULL  = 8'd255;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [OFFS_W-1:0] mark_x;
    logic [OFFS_W-1:0] mark_y;
    logic [DIM_W-1:0]  mark_width;
    logic [DIM_W-1:0]  mark_height;
  } awb_cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] luma_size;
    logic [FSZ_W-1:0]  frame_size;
  } awb_geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
  } awb_pixel_t;

  typedef struct packed {
    logic              luma_write;
    logic [ADDR_W-1:0] luma_addr;
    logic [PIX_W-1:0]  luma_value;
    logic              cb_write;
    logic [ADDR_W-1:0] cb_addr;
    logic [PIX_W-1:0]  cb_value;
    logic              cr_write;
    logic [ADDR_W-1:0] cr_addr;
    logic [PIX_W-1:0]  cr_value;
  } awb_result_t;

endpackage

/* hw/rtl/awb_cfg_regs.sv */
module awb_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [awb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output awb_pkg::awb_cfg_t                cfg,
  output awb_pkg::awb_geom_t               geom
);
  import awb_pkg::*;

  logic [SIZE_W-1:0] luma_size_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
      cfg.mark_x       <= MARK_X_RST;
      cfg.mark_y       <= MARK_Y_RST;
      cfg.mark_width   <= MARK_WIDTH_RST;
      cfg.mark_height  <= MARK_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        REG_MARK_X:       cfg.mark_x       <= cfg_data[OFFS_W-1:0];
        REG_MARK_Y:       cfg.mark_y       <= cfg_data[OFFS_W-1:0];
        REG_MARK_WIDTH:   cfg.mark_width   <= cfg_data;
        REG_MARK_HEIGHT:  cfg.mark_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Plane sizes follow the registers in the cycle after they change.
  assign luma_size_next = cfg.frame_width * cfg.frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.luma_size  <= LUMA_SIZE_RST;
      geom.frame_size <= FRAME_SIZE_RST;
    end else begin
      geom.luma_size  <= luma_size_next;
      geom.frame_size <= FSZ_W'(({1'b0, luma_size_next, 1'b0} +
                                 {2'b0, luma_size_next}) >> 1);
    end
  end

endmodule

/* hw/rtl/awb_position.sv */
module awb_position (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  awb_pkg::awb_cfg_t         cfg,
  output logic [awb_pkg::CNT_W-1:0] mark_column,
  output logic [awb_pkg::CNT_W-1:0] mark_row
);
  import awb_pkg::*;

  logic [INC_W-1:0] column_inc;
  logic [INC_W-1:0] row_inc;
  logic             column_wrap;
  logic             row_wrap;

  // A zero watermark size behaves like one, since the incremented value
  // always reaches it.
  assign column_inc  = INC_W'(mark_column) + INC_W'(1);
  assign row_inc     = INC_W'(mark_row) + INC_W'(1);
  assign column_wrap = (column_inc >= INC_W'(cfg.mark_width)) ||
                       (column_inc >= INC_W'(MAX_FRAME_DIM));
  assign row_wrap    = (row_inc >= INC_W'(cfg.mark_height)) ||
                       (row_inc >= INC_W'(MAX_FRAME_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_column <= '0;
      mark_row    <= '0;
    end else if (advance) begin
      if (column_wrap) begin
        mark_column <= '0;
        mark_row    <= row_wrap ? '0 : row_inc[CNT_W-1:0];
      end else begin
        mark_column <= column_inc[CNT_W-1:0];
      end
    end
  end

endmodule

/* hw/rtl/awb_datapath.sv */
module awb_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  awb_pkg::awb_pixel_t       pixel,
  input  logic [awb_pkg::CNT_W-1:0] mark_column,
  input  logic [awb_pkg::CNT_W-1:0] mark_row,
  input  awb_pkg::awb_cfg_t         cfg,
  input  awb_pkg::awb_geom_t        geom,
  output logic                      out_valid,
  input  logic                      out_ready,
  output awb_pkg::awb_result_t      result
);
  import awb_pkg::*;

  function automatic logic [PIX_W-1:0] conv_sample(
    input logic signed [SUM_W-1:0] s,
    input logic [PIX_W-1:0]        bias
  );
    logic signed [SUM_W-1:0] t;
    t = s + ROUND_HALF;
    // Bits 15:8 are the low byte of the floor shift by eight.
    return t[15:8] + bias;
  endfunction

  // floor(x / 255) for x up to 255 * 255 is (x + (x >> 8) + 1) >> 8.
  function automatic logic [PIX_W-1:0] blend_sample(
    input logic [PIX_W-1:0] old_v,
    input logic [PIX_W-1:0] new_v,
    input logic [PIX_W-1:0] a
  );
    logic [2*PIX_W-1:0] x;
    logic [2*PIX_W:0]   q;
    x = {8'b0, new_v} * {8'b0, a} + {8'b0, old_v} * {8'b0, ALPHA_FULL - a};
    q = {1'b0, x} + (2*PIX_W+1)'(x[2*PIX_W-1:PIX_W]) + (2*PIX_W+1)'(1);
    return q[2*PIX_W-1:PIX_W];
  endfunction

  logic                    stage_valid;
  awb_pixel_t              stage_pix;
  logic [CNT_W-1:0]        stage_col;
  logic [CNT_W-1:0]        stage_row;
  logic                    out_advance;

  logic signed [SUM_W-1:0] r_s;
  logic signed [SUM_W-1:0] g_s;
  logic signed [SUM_W-1:0] b_s;
  logic [PIX_W-1:0]        y_new;
  logic [PIX_W-1:0]        u_new;
  logic [PIX_W-1:0]        v_new;

  logic [POS_W-1:0]        luma_row;
  logic [POS_W-1:0]        chroma_row;
  logic [POS_W+DIM_W-1:0]  luma_prod;
  logic [POS_W+DIM_W-1:0]  chroma_prod;
  logic [ADDR_FULL_W-1:0]  luma_full;
  logic [ADDR_FULL_W-1:0]  cb_full;
  logic [ADDR_FULL_W-1:0]  cr_full;
  logic [ADDR_FULL_W-1:0]  frame_size;
  logic                    opaque;
  logic                    even_pos;
  awb_result_t             result_next;

  // The input stage moves on whenever the result register is free or
  // its word is being taken.
  assign out_advance = !out_valid || out_ready;
  assign in_ready    = !stage_valid || out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_pix <= pixel;
      stage_col <= mark_column;
      stage_row <= mark_row;
    end
  end

  assign r_s = $signed({10'b0, stage_pix.red});
  assign g_s = $signed({10'b0, stage_pix.green});
  assign b_s = $signed({10'b0, stage_pix.blue});

  assign y_new = conv_sample(CY_R * r_s + CY_G * g_s + CY_B * b_s, LUMA_BIAS);
  assign u_new = conv_sample(CU_R * r_s + CU_G * g_s + CU_B * b_s, CHROMA_BIAS);
  assign v_new = conv_sample(CV_R * r_s + CV_G * g_s + CV_B * b_s, CHROMA_BIAS);

  assign luma_row    = POS_W'(stage_row) + POS_W'(cfg.mark_y);
  assign chroma_row  = POS_W'(stage_row >> 1) + POS_W'(cfg.mark_y >> 1);
  assign luma_prod   = luma_row * cfg.frame_width;
  assign chroma_prod = chroma_row * cfg.frame_width;

  assign luma_full = ADDR_FULL_W'(luma_prod) + ADDR_FULL_W'(stage_col) +
                     ADDR_FULL_W'(cfg.mark_x);
  assign cb_full   = ADDR_FULL_W'(geom.luma_size) + ADDR_FULL_W'(chroma_prod >> 1) +
                     ADDR_FULL_W'(stage_col >> 1) + ADDR_FULL_W'(cfg.mark_x >> 1);
  assign cr_full   = cb_full + ADDR_FULL_W'(geom.luma_size >> 2);
  assign frame_size = ADDR_FULL_W'(geom.frame_size);

  assign opaque   = |stage_pix.alpha;
  assign even_pos = !stage_col[0] && !stage_row[0];

  always_comb begin
    result_next.luma_write = opaque && (luma_full < frame_size);
    result_next.luma_addr  = luma_full[ADDR_W-1:0];
    result_next.luma_value = blend_sample(stage_pix.luma, y_new, stage_pix.alpha);
    result_next.cb_write   = opaque && even_pos && (cb_full < frame_size);
    result_next.cb_addr    = cb_full[ADDR_W-1:0];
    result_next.cb_value   = blend_sample(stage_pix.cb, u_new, stage_pix.alpha);
    result_next.cr_write   = opaque && even_pos && (cr_full < frame_size);
    result_next.cr_addr    = cr_full[ADDR_W-1:0];
    result_next.cr_value   = blend_sample(stage_pix.cr, v_new, stage_pix.alpha);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && stage_valid) begin
      result <= result_next;
    end
  end

endmodule

/* hw/rtl/argb_watermark_blend_i420.sv */
// An accepted word passes from the input register to the result register, which
// drives the result ports. Throughput: one word per cycle while out_ready is high;
// the two registers form a two-entry pipeline, so a new word is taken while a result waits.
// Reset (rst, synchronous, active high) empties the pipeline, zeroes the
// watermark position counters and loads the registers with 640x480, 64x64 at 0,0.
module argb_watermark_blend_i420 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [awb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [awb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [awb_pkg::PIX_W-1:0]          mark_alpha,
  input  logic [awb_pkg::PIX_W-1:0]          mark_red,
  input  logic [awb_pkg::PIX_W-1:0]          mark_green,
  input  logic [awb_pkg::PIX_W-1:0]          mark_blue,
  input  logic [awb_pkg::PIX_W-1:0]          orig_luma,
  input  logic [awb_pkg::PIX_W-1:0]          orig_cb,
  input  logic [awb_pkg::PIX_W-1:0]          orig_cr,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               luma_write,
  output logic [awb_pkg::ADDR_W-1:0]         luma_addr,
  output logic [awb_pkg::PIX_W-1:0]          luma_value,
  output logic                               cb_write,
  output logic [awb_pkg::ADDR_W-1:0]         cb_addr,
  output logic [awb_pkg::PIX_W-1:0]          cb_value,
  output logic                               cr_write,
  output logic [awb_pkg::ADDR_W-1:0]         cr_addr,
  output logic [awb_pkg::PIX_W-1:0]          cr_value
);
  import awb_pkg::*;

  // The watermark arrives in row-major order. Each word is converted to
  // BT.601 YUV and blended with the original samples the caller fetched
  // for the addresses this block reports. Chroma writes are only flagged
  // on even columns and rows, and every write needs nonzero alpha and an
  // address inside the I420 frame.
  //
  // The configuration registers feed a registered copy of the plane sizes,
  // so a register write reaches the plane sizes only once that copy has updated.
  // The position counters advance on every accepted word and are not
  // touched by configuration writes.

  awb_cfg_t         cfg;
  awb_geom_t        geom;
  awb_pixel_t       pixel;
  awb_result_t      result;
  logic [CNT_W-1:0] mark_column;
  logic [CNT_W-1:0] mark_row;

  assign pixel.alpha = mark_alpha;
  assign pixel.red   = mark_red;
  assign pixel.green = mark_green;
  assign pixel.blue  = mark_blue;
  assign pixel.luma  = orig_luma;
  assign pixel.cb    = orig_cb;
  assign pixel.cr    = orig_cr;

  awb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .geom      (geom)
  );

  // The counters hold the position of the word on the input port; the
  // datapath captures them together with the word.
  awb_position u_position (
    .clk         (clk),
    .rst         (rst),
    .advance     (in_valid && in_ready),
    .cfg         (cfg),
    .mark_column (mark_column),
    .mark_row    (mark_row)
  );

  awb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .mark_column (mark_column),
    .mark_row    (mark_row),
    .cfg         (cfg),
    .geom        (geom),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  assign luma_write = result.luma_write;
  assign luma_addr  = result.luma_addr;
  assign luma_value = result.luma_value;
  assign cb_write   = result.cb_write;
  assign cb_addr    = result.cb_addr;
  assign cb_value   = result.cb_value;
  assign cr_write   = result.cr_write;
  assign cr_addr    = result.cr_addr;
  assign cr_value   = result.cr_value;

endmodule

/* hw/rtl/awb_checker.sv */
module awb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       luma_write,
  input logic [awb_pkg::ADDR_W-1:0] luma_addr,
  input logic                       cb_write,
  input logic [awb_pkg::ADDR_W-1:0] cb_addr,
  input logic                       cr_write,
  input logic [awb_pkg::ADDR_W-1:0] cr_addr
);

  // The input only stalls when the result register holds a word not taken.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the result register could move");

  // The V plane lies after the U plane, so a V write implies a U write.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && cr_write) |-> cb_write)
    else $error("V write flagged without the matching U write");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped before it was taken");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      ($stable(luma_addr) && $stable(cb_addr) && $stable(cr_addr) &&
       $stable(luma_write)))
    else $error("stalled result word changed");

endmodule

bind argb_watermark_blend_i420 awb_checker u_awb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .luma_write (luma_write),
  .luma_addr  (luma_addr),
  .cb_write   (cb_write),
  .cb_addr    (cb_addr),
  .cr_write   (cr_write),
  .cr_addr    (cr_addr)
);
